### rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5 package
// shared types, constants and round functions of the md5 compression block
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ADDR_W      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 4;
    localparam int OUT_IDX_W   = $clog2(DIGEST_WORDS);

    localparam logic [ADDR_W-1:0]    LAST_ADDR  = ADDR_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0]   LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [OUT_IDX_W-1:0] LAST_OUT   = OUT_IDX_W'(DIGEST_WORDS - 1);

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } md5_state_t;

    localparam logic [WORD_W-1:0] SINE_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // rotate amount: row from the round group, column from the low round bits
    function automatic logic [4:0] rot_amt(input logic [ROUND_W-1:0] r);
        return ROT_AMT[{r[5:4], r[1:0]}];
    endfunction

    // message word index used by round r
    function automatic logic [ADDR_W-1:0] msg_idx(input logic [ROUND_W-1:0] r);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] idx;
        lo = r[ADDR_W-1:0];
        case (r[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = ADDR_W'(lo * 4'd5 + 4'd1);
            2'd2:    idx = ADDR_W'(lo * 4'd3 + 4'd5);
            default: idx = ADDR_W'(lo * 4'd7);
        endcase
        return idx;
    endfunction

    // F, G, H, I by round group
    function automatic logic [WORD_W-1:0] round_fn(
        input logic [ROUND_W-1:0] r,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        case (r[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/md5_ram.sv
// ----------------------------------------------------------------------------
// md5 ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/md5_block_compression.sv
// ----------------------------------------------------------------------------
// md5 block compression
// absorbs a padded message word by word and emits the 128-bit md5 digest
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one beat per 32-bit little-endian message word,
//   s_tlast on the final word of the final padded block
//   output channel m_*: four beats per message, digest words A, B, C, D,
//   m_tuser gives the word index, m_tlast marks the D word
//   a word that does not complete a block is taken without a stall
//   the 16th word of a block starts compression: a load step, 64 rounds
//   (one round per cycle, bound by the single buffer read port) and a
//   final step that adds the working registers into the chaining value
//   the digest follows the last word: 4 beats, one per cycle when m_tready
//   is high; a stalled beat holds and no input is taken until D is gone
//   a last flag inside a block drops the partial block
//   after the D beat the chaining value returns to the md5 initial vector
//   reset clears the control state and loads the initial vector; the block
//   buffer is not cleared since every entry is written before it is read
// ----------------------------------------------------------------------------
`default_nettype none

module md5_block_compression (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // message words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // message_word
    input  wire logic        s_tlast,   // last_word
    // digest words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // digest_word
    output logic      [1:0]  m_tuser,   // word_index
    output logic             m_tlast    // last_result
);

    import md5_pkg::*;

    md5_state_t state_reg, state_next;

    logic [ADDR_W-1:0]    word_cnt_reg, word_cnt_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                 last_reg, last_next;

    // chaining value and working registers a..d
    logic [WORD_W-1:0] chain_reg [DIGEST_WORDS];
    logic [WORD_W-1:0] chain_next [DIGEST_WORDS];
    logic [WORD_W-1:0] work_reg [DIGEST_WORDS];
    logic [WORD_W-1:0] work_next [DIGEST_WORDS];

    // block buffer port
    logic              buf_wr_en;
    logic              buf_rd_en;
    logic [ADDR_W-1:0] buf_rd_addr;
    logic [WORD_W-1:0] buf_rd_data;

    // round datapath
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] round_sum;
    logic [63:0]       rot_dbl;
    logic [WORD_W-1:0] new_b;

    logic in_beat;
    logic out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (word_cnt_reg),
        .wr_data (s_tdata),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // one md5 round: buffer data for this round arrives from the read issued
    // in the previous cycle
    always_comb
    begin
        f_val     = round_fn(round_reg, work_reg[1], work_reg[2], work_reg[3]);
        round_sum = work_reg[0] + f_val + SINE_K[round_reg] + buf_rd_data;
        rot_dbl   = {round_sum, round_sum} << rot_amt(round_reg);
        new_b     = work_reg[1] + rot_dbl[63:32];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (word_cnt_reg == LAST_ADDR)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_beat && out_idx_reg == LAST_OUT)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and buffer control
    always_comb
    begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        buf_rd_en   = 1'b0;
        buf_rd_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_LOAD:
            begin
                buf_rd_en   = 1'b1;
                buf_rd_addr = msg_idx('0);
            end
            ST_ROUND:
            begin
                // prefetch the word for the following round
                buf_rd_en   = 1'b1;
                buf_rd_addr = msg_idx(round_reg + 1'b1);
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign buf_wr_en = in_beat;
    assign m_tdata   = chain_reg[out_idx_reg];
    assign m_tuser   = out_idx_reg;
    assign m_tlast   = (out_idx_reg == LAST_OUT);

    // datapath next values
    always_comb
    begin
        word_cnt_next = word_cnt_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        last_next     = last_reg;
        chain_next    = chain_reg;
        work_next     = work_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                    last_next     = s_tlast;
                end
            end
            ST_LOAD:
            begin
                work_next  = chain_reg;
                round_next = '0;
            end
            ST_ROUND:
            begin
                work_next[0] = work_reg[3];
                work_next[1] = new_b;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                round_next   = round_reg + 1'b1;
            end
            ST_FINAL:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                    work_next[i]  = chain_reg[i] + work_reg[i];
                end
            end
            ST_OUT:
            begin
                if (out_beat)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == LAST_OUT)
                    begin
                        chain_next[0] = IV_A;
                        chain_next[1] = IV_B;
                        chain_next[2] = IV_C;
                        chain_next[3] = IV_D;
                        word_cnt_next = '0;
                        last_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                last_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            word_cnt_reg <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            last_reg     <= 1'b0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            last_reg     <= last_next;
            chain_reg    <= chain_next;
            work_reg     <= work_next;
        end
    end

endmodule

`default_nettype wire

### rtl/md5_chk.sv
// ----------------------------------------------------------------------------
// md5 checker
// port-level assertions on the md5 compression block's digest channel
// ----------------------------------------------------------------------------
`default_nettype none

module md5_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // no message word is taken while a digest is going out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
    else $error("input ready while digest pending");

    // the D word and only the D word carries tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
    else $error("tlast does not match word index");

    // digest words follow in order A, B, C, D without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == $past(m_tuser) + 2'd1)))
    else $error("digest words out of order");

    // a stalled digest beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled digest beat changed");

endmodule

bind md5_block_compression md5_chk u_md5_chk (.*);

`default_nettype wire
